// ===== hdl/pbpr_pkg.sv =====
`timescale 1ns / 1ps

package pbpr_pkg;

    // Bar classification codes
    localparam logic [1:0] KIND_NEUTRAL = 2'd0;
    localparam logic [1:0] KIND_OUTSIDE = 2'd1;
    localparam logic [1:0] KIND_INSIDE  = 2'd2;

    // Configuration register indexes
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int REG_W = 16;

    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE_RANGE_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE_RANGE_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE_VOLUME_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE_VOLUME_HIGH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INSIDE_RANGE_LOOSE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INSIDE_RANGE_TIGHT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INSIDE_VOLUME_LOOSE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INSIDE_VOLUME_TIGHT = 3'd7;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = {
        16'd20, 16'd50, 16'd10, 16'd25, 16'd300, 16'd150, 16'd900, 16'd500
    };

    // Ratios are in percent
    localparam int RATIO_SCALE = 100;

    // Rank fields
    localparam int HALF_W = 4;
    localparam int LEVEL_W = 3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;
    localparam logic [HALF_W-1:0] BASE_HALF = 4'd2;

    // Pipeline load enables
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic out_load;
    } pipe_ctrl_t;

endpackage

// ===== hdl/pbpr_classify.sv =====
`timescale 1ns / 1ps

module pbpr_classify #(
    parameter int HISTORY_DEPTH = 4,
    parameter int PRICE_BITS = 32,
    parameter int VOLUME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbpr_pkg::pipe_ctrl_t   ctrl,
    input  logic [PRICE_BITS-1:0]  bar_high,
    input  logic [PRICE_BITS-1:0]  bar_low,
    input  logic [VOLUME_BITS-1:0] bar_volume,
    input  logic                   series_start,
    output logic [1:0]             kind_reg,
    output logic [pbpr_pkg::HALF_W-1:0] base_half_reg,
    output logic [PRICE_BITS-1:0]  range_reg,
    output logic [PRICE_BITS-1:0]  prev_range_reg,
    output logic [VOLUME_BITS-1:0] volume_reg,
    output logic [VOLUME_BITS-1:0] prev_volume_reg
);
    import pbpr_pkg::*;

    localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);

    logic [PRICE_BITS-1:0]  high_hist_reg [HISTORY_DEPTH];
    logic [PRICE_BITS-1:0]  low_hist_reg [HISTORY_DEPTH];
    logic [VOLUME_BITS-1:0] last_volume_reg;
    logic [SEEN_W-1:0]      seen_reg;
    logic [SEEN_W-1:0]      seen_next;

    logic [SEEN_W-1:0]      seen_eff;
    logic                   is_outside;
    logic                   is_inside;
    logic [HISTORY_DEPTH-1:0] engulf;
    logic [HALF_W-1:0]      chain;
    logic                   chain_open;
    logic [1:0]             kind_next;
    logic [HALF_W-1:0]      base_half_next;
    logic [PRICE_BITS-1:0]  range_next;
    logic [PRICE_BITS-1:0]  prev_range_next;

    // A series start hides all held bars
    assign seen_eff = series_start ? '0 : seen_reg;

    // Engulf test against each held bar
    always_comb
    begin
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            engulf[k] = (bar_high > high_hist_reg[k]) && (bar_low < low_hist_reg[k]);
        end
    end

    // Count the unbroken engulfing chain behind the previous bar
    always_comb
    begin
        chain = '0;
        chain_open = 1'b1;
        for (int k = 1; k < HISTORY_DEPTH; k++)
        begin
            if (chain_open && (SEEN_W'(k) < seen_eff) && engulf[k])
            begin
                chain = chain + 1'b1;
            end
            else
            begin
                chain_open = 1'b0;
            end
        end
    end

    // Classify against the previous bar
    assign is_outside = (seen_eff != '0) && engulf[0];
    assign is_inside  = (seen_eff != '0) && (bar_high < high_hist_reg[0])
                        && (bar_low > low_hist_reg[0]) && (bar_volume != '0)
                        && (last_volume_reg != '0);

    always_comb
    begin
        if (is_outside)
        begin
            kind_next = KIND_OUTSIDE;
            base_half_next = BASE_HALF + chain;
        end
        else if (is_inside)
        begin
            kind_next = KIND_INSIDE;
            base_half_next = BASE_HALF;
        end
        else
        begin
            kind_next = KIND_NEUTRAL;
            base_half_next = '0;
        end
    end

    // Ranges saturate to zero for inverted bars
    assign range_next = (bar_high > bar_low) ? (bar_high - bar_low) : '0;
    assign prev_range_next = (high_hist_reg[0] > low_hist_reg[0])
                             ? (high_hist_reg[0] - low_hist_reg[0]) : '0;

    // Advance the bar count, saturating at the history depth
    always_comb
    begin
        if (series_start)
        begin
            seen_next = SEEN_W'(1);
        end
        else if (seen_reg < SEEN_W'(HISTORY_DEPTH))
        begin
            seen_next = seen_reg + 1'b1;
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (ctrl.s1_load)
        begin
            seen_reg <= seen_next;
        end
    end

    // Shift history and capture the stage register on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            for (int k = HISTORY_DEPTH - 1; k > 0; k--)
            begin
                high_hist_reg[k] <= high_hist_reg[k-1];
                low_hist_reg[k] <= low_hist_reg[k-1];
            end
            high_hist_reg[0] <= bar_high;
            low_hist_reg[0] <= bar_low;
            last_volume_reg <= bar_volume;

            kind_reg <= kind_next;
            base_half_reg <= base_half_next;
            range_reg <= range_next;
            prev_range_reg <= prev_range_next;
            volume_reg <= bar_volume;
            prev_volume_reg <= last_volume_reg;
        end
    end

endmodule

// ===== hdl/pbpr_score.sv =====
`timescale 1ns / 1ps

module pbpr_score #(
    parameter int PRICE_BITS = 32,
    parameter int VOLUME_BITS = 32
) (
    input  logic                   clk,
    input  pbpr_pkg::pipe_ctrl_t   ctrl,
    input  pbpr_pkg::cfg_regs_t    cfg,
    input  logic [1:0]             kind,
    input  logic [pbpr_pkg::HALF_W-1:0] base_half,
    input  logic [PRICE_BITS-1:0]  range_val,
    input  logic [PRICE_BITS-1:0]  prev_range,
    input  logic [VOLUME_BITS-1:0] volume,
    input  logic [VOLUME_BITS-1:0] prev_volume,
    output logic [1:0]             kind_out_reg,
    output logic [pbpr_pkg::HALF_W-1:0]  half_out_reg,
    output logic [pbpr_pkg::LEVEL_W-1:0] level_out_reg
);
    import pbpr_pkg::*;

    localparam int RPW = PRICE_BITS + REG_W;
    localparam int VPW = VOLUME_BITS + REG_W;

    logic [REG_W-1:0]  range_pct_a;
    logic [REG_W-1:0]  range_pct_b;
    logic [REG_W-1:0]  volume_pct_a;
    logic [REG_W-1:0]  volume_pct_b;

    logic [1:0]        kind_reg;
    logic [HALF_W-1:0] base_reg;
    logic [RPW-1:0]    range100_reg;
    logic [RPW-1:0]    range_prod_a_reg;
    logic [RPW-1:0]    range_prod_b_reg;
    logic              range_nz_reg;
    logic              prev_range_zero_reg;
    logic [VPW-1:0]    volume100_reg;
    logic [VPW-1:0]    volume_prod_a_reg;
    logic [VPW-1:0]    volume_prod_b_reg;
    logic              volume_nz_reg;
    logic              prev_volume_zero_reg;

    logic [3:0]        pass;
    logic [HALF_W-1:0] points;
    logic [HALF_W-1:0] half_next;
    logic [LEVEL_W-1:0] level_next;

    // Pick the range and volume threshold pairs for the bar kind
    always_comb
    begin
        if (kind == KIND_OUTSIDE)
        begin
            range_pct_a  = cfg[REG_OUTSIDE_RANGE_LOW];
            range_pct_b  = cfg[REG_OUTSIDE_RANGE_HIGH];
            volume_pct_a = cfg[REG_OUTSIDE_VOLUME_LOW];
            volume_pct_b = cfg[REG_OUTSIDE_VOLUME_HIGH];
        end
        else
        begin
            range_pct_a  = cfg[REG_INSIDE_RANGE_LOOSE];
            range_pct_b  = cfg[REG_INSIDE_RANGE_TIGHT];
            volume_pct_a = cfg[REG_INSIDE_VOLUME_LOOSE];
            volume_pct_b = cfg[REG_INSIDE_VOLUME_TIGHT];
        end
    end

    // Register the cross products: value * 100 and pct * previous value
    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            kind_reg <= kind;
            base_reg <= base_half;
            range100_reg <= RPW'(range_val) * RPW'(RATIO_SCALE);
            range_prod_a_reg <= RPW'(range_pct_a) * RPW'(prev_range);
            range_prod_b_reg <= RPW'(range_pct_b) * RPW'(prev_range);
            range_nz_reg <= (range_val != '0);
            prev_range_zero_reg <= (prev_range == '0);
            volume100_reg <= VPW'(volume) * VPW'(RATIO_SCALE);
            volume_prod_a_reg <= VPW'(volume_pct_a) * VPW'(prev_volume);
            volume_prod_b_reg <= VPW'(volume_pct_b) * VPW'(prev_volume);
            volume_nz_reg <= (volume != '0);
            prev_volume_zero_reg <= (prev_volume == '0);
        end
    end

    // Compare ratios; a zero denominator passes nonzero outside values, no inside ones
    always_comb
    begin
        if (kind_reg == KIND_OUTSIDE)
        begin
            pass[0] = prev_range_zero_reg ? range_nz_reg : (range100_reg >= range_prod_a_reg);
            pass[1] = prev_range_zero_reg ? range_nz_reg : (range100_reg >= range_prod_b_reg);
            pass[2] = prev_volume_zero_reg ? volume_nz_reg
                                           : (volume100_reg >= volume_prod_a_reg);
            pass[3] = prev_volume_zero_reg ? volume_nz_reg
                                           : (volume100_reg >= volume_prod_b_reg);
        end
        else if (kind_reg == KIND_INSIDE)
        begin
            pass[0] = !prev_range_zero_reg && (range100_reg <= range_prod_a_reg);
            pass[1] = !prev_range_zero_reg && (range100_reg <= range_prod_b_reg);
            pass[2] = !prev_volume_zero_reg && (volume100_reg <= volume_prod_a_reg);
            pass[3] = !prev_volume_zero_reg && (volume100_reg <= volume_prod_b_reg);
        end
        else
        begin
            pass = '0;
        end
    end

    // Sum the half points and derive the whole level
    always_comb
    begin
        points = HALF_W'(pass[0]) + HALF_W'(pass[1]) + HALF_W'(pass[2]) + HALF_W'(pass[3]);
        half_next = base_reg + points;
        if (half_next[HALF_W-1:1] > LEVEL_MAX)
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = LEVEL_W'(half_next[HALF_W-1:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            kind_out_reg <= kind_reg;
            half_out_reg <= half_next;
            level_out_reg <= level_next;
        end
    end

endmodule

// ===== hdl/price_bar_pattern_ranker.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted bar transaction passes through the classify stage register,
// the cross-product stage register, then compare and sum into the output register.
// Throughput: one bar per cycle; the pipeline stalls only when the output is held.
// Reset: rst_n clears the held-bar count (hiding the bar history), pipeline valids and
// restores the default thresholds; the first bar after reset or series_start is neutral.
module price_bar_pattern_ranker #(
    parameter int HISTORY_DEPTH = 4,
    parameter int PRICE_BITS = 32,
    parameter int VOLUME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   bar_valid,
    output logic                   bar_ready,
    input  logic [PRICE_BITS-1:0]  bar_high,
    input  logic [PRICE_BITS-1:0]  bar_low,
    input  logic [VOLUME_BITS-1:0] bar_volume,
    input  logic                   series_start,
    output logic                   rank_valid,
    input  logic                   rank_ready,
    output logic [1:0]             bar_kind,
    output logic [3:0]             rank_half_points,
    output logic [2:0]             rank_level,
    input  logic                   cfg_write_en,
    input  logic [pbpr_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [pbpr_pkg::REG_W-1:0]     cfg_data
);
    import pbpr_pkg::*;

    cfg_regs_t  cfg_reg;
    pipe_ctrl_t ctrl;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    logic [1:0]             s1_kind;
    logic [HALF_W-1:0]      s1_base_half;
    logic [PRICE_BITS-1:0]  s1_range;
    logic [PRICE_BITS-1:0]  s1_prev_range;
    logic [VOLUME_BITS-1:0] s1_volume;
    logic [VOLUME_BITS-1:0] s1_prev_volume;

    // Write threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Advance each stage when the one after it is empty or moving
    always_comb
    begin
        ctrl.out_load = s2_valid_reg && (!out_valid_reg || rank_ready);
        ctrl.s2_load  = s1_valid_reg && (!s2_valid_reg || ctrl.out_load);
        ctrl.s1_load  = bar_valid && bar_ready;
    end

    assign bar_ready = !s1_valid_reg || ctrl.s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (ctrl.s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (ctrl.s2_load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (ctrl.out_load)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rank_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rank_valid = out_valid_reg;

    pbpr_classify #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRICE_BITS    (PRICE_BITS),
        .VOLUME_BITS   (VOLUME_BITS)
    ) u_classify (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .bar_high        (bar_high),
        .bar_low         (bar_low),
        .bar_volume      (bar_volume),
        .series_start    (series_start),
        .kind_reg        (s1_kind),
        .base_half_reg   (s1_base_half),
        .range_reg       (s1_range),
        .prev_range_reg  (s1_prev_range),
        .volume_reg      (s1_volume),
        .prev_volume_reg (s1_prev_volume)
    );

    pbpr_score #(
        .PRICE_BITS  (PRICE_BITS),
        .VOLUME_BITS (VOLUME_BITS)
    ) u_score (
        .clk           (clk),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .kind          (s1_kind),
        .base_half     (s1_base_half),
        .range_val     (s1_range),
        .prev_range    (s1_prev_range),
        .volume        (s1_volume),
        .prev_volume   (s1_prev_volume),
        .kind_out_reg  (bar_kind),
        .half_out_reg  (rank_half_points),
        .level_out_reg (rank_level)
    );

endmodule

// ===== test/price_bar_pattern_ranker_tb.sv =====
`timescale 1ns / 1ps

module price_bar_pattern_ranker_tb;

    import pbpr_pkg::*;

    localparam int HISTORY_BARS   = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 50;

    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] volume;
        logic        start;
    } bar_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [HALF_W-1:0]  half;
        logic [LEVEL_W-1:0] level;
    } rank_t;

    typedef enum {THR_ZERO, THR_FULL, THR_RANDOM, THR_DEFAULT} thr_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    logic                 bar_valid = 1'b0;
    logic                 bar_ready;
    logic [31:0]          bar_high = '0;
    logic [31:0]          bar_low = '0;
    logic [31:0]          bar_volume = '0;
    logic                 series_start = 1'b0;
    logic                 rank_valid;
    logic                 rank_ready = 1'b0;
    logic [1:0]           bar_kind;
    logic [3:0]           rank_half_points;
    logic [2:0]           rank_level;
    logic                 cfg_write_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;

    // Stimulus and expected ranks
    bar_t  bars_to_send[$];
    rank_t ranks_due[$];
    bar_t  on_wire;
    rank_t next_due;

    // Predictor copy of history and thresholds
    logic [31:0] prior_high [HISTORY_BARS];
    logic [31:0] prior_low [HISTORY_BARS];
    logic [31:0] prior_volume = '0;
    int          bars_held = 0;
    logic [15:0] thr [NUM_REGS];

    // Generator view of the last queued bar
    logic [31:0] gen_high = '0;
    logic [31:0] gen_low = '0;
    logic [31:0] gen_vol = '0;
    int          bars_added = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    price_bar_pattern_ranker u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .bar_valid        (bar_valid),
        .bar_ready        (bar_ready),
        .bar_high         (bar_high),
        .bar_low          (bar_low),
        .bar_volume       (bar_volume),
        .series_start     (series_start),
        .rank_valid       (rank_valid),
        .rank_ready       (rank_ready),
        .bar_kind         (bar_kind),
        .rank_half_points (rank_half_points),
        .rank_level       (rank_level),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (mismatches < MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic [15:0] default_threshold(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_OUTSIDE_RANGE_LOW:   return 16'd500;
            REG_OUTSIDE_RANGE_HIGH:  return 16'd900;
            REG_OUTSIDE_VOLUME_LOW:  return 16'd150;
            REG_OUTSIDE_VOLUME_HIGH: return 16'd300;
            REG_INSIDE_RANGE_LOOSE:  return 16'd25;
            REG_INSIDE_RANGE_TIGHT:  return 16'd10;
            REG_INSIDE_VOLUME_LOOSE: return 16'd50;
            default:                 return 16'd20;
        endcase
    endfunction

    function automatic logic [31:0] price_span(input logic [31:0] hi, input logic [31:0] lo);
        return (hi > lo) ? hi - lo : 32'd0;
    endfunction

    // num/den in percent at or above pct; zero den counts as infinite
    function automatic bit ratio_reaches(input logic [31:0] num, input logic [31:0] den,
                                         input logic [15:0] pct);
        if (den == '0)
        begin
            return num != '0;
        end
        return (64'(num) * 64'd100) >= (64'(pct) * 64'(den));
    endfunction

    // num/den in percent at or below pct; zero den never qualifies
    function automatic bit ratio_within(input logic [31:0] num, input logic [31:0] den,
                                        input logic [15:0] pct);
        if (den == '0)
        begin
            return 1'b0;
        end
        return (64'(num) * 64'd100) <= (64'(pct) * 64'(den));
    endfunction

    // Classify one bar, score it, then push it into the history
    function automatic rank_t rank_bar(input bar_t b);
        rank_t       r;
        logic [31:0] cur_span;
        logic [31:0] prev_span;
        logic        chain_open;
        int          k;
        r.kind = KIND_NEUTRAL;
        r.half = '0;
        r.level = '0;
        if (b.start)
        begin
            for (k = 0; k < HISTORY_BARS; k++)
            begin
                prior_high[k] = '0;
                prior_low[k] = '0;
            end
            prior_volume = '0;
            bars_held = 0;
        end
        if (bars_held > 0)
        begin
            cur_span = price_span(b.high, b.low);
            prev_span = price_span(prior_high[0], prior_low[0]);
            if (b.high > prior_high[0] && b.low < prior_low[0])
            begin
                r.kind = KIND_OUTSIDE;
                r.half = 4'd2;
                chain_open = 1'b1;
                for (k = 1; k < HISTORY_BARS; k++)
                begin
                    if (chain_open && k < bars_held &&
                        b.high > prior_high[k] && b.low < prior_low[k])
                    begin
                        r.half++;
                    end
                    else
                    begin
                        chain_open = 1'b0;
                    end
                end
                if (ratio_reaches(cur_span, prev_span, thr[REG_OUTSIDE_RANGE_LOW]))
                    r.half++;
                if (ratio_reaches(cur_span, prev_span, thr[REG_OUTSIDE_RANGE_HIGH]))
                    r.half++;
                if (ratio_reaches(b.volume, prior_volume, thr[REG_OUTSIDE_VOLUME_LOW]))
                    r.half++;
                if (ratio_reaches(b.volume, prior_volume, thr[REG_OUTSIDE_VOLUME_HIGH]))
                    r.half++;
            end
            else if (b.high < prior_high[0] && b.low > prior_low[0] &&
                     b.volume != '0 && prior_volume != '0)
            begin
                r.kind = KIND_INSIDE;
                r.half = 4'd2;
                if (ratio_within(cur_span, prev_span, thr[REG_INSIDE_RANGE_LOOSE]))
                    r.half++;
                if (ratio_within(cur_span, prev_span, thr[REG_INSIDE_RANGE_TIGHT]))
                    r.half++;
                if (ratio_within(b.volume, prior_volume, thr[REG_INSIDE_VOLUME_LOOSE]))
                    r.half++;
                if (ratio_within(b.volume, prior_volume, thr[REG_INSIDE_VOLUME_TIGHT]))
                    r.half++;
            end
        end
        r.level = ((r.half >> 1) > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(r.half >> 1);

        // Shift history, newest bar into slot zero
        for (k = HISTORY_BARS - 1; k > 0; k--)
        begin
            prior_high[k] = prior_high[k - 1];
            prior_low[k] = prior_low[k - 1];
        end
        prior_high[0] = b.high;
        prior_low[0] = b.low;
        prior_volume = b.volume;
        if (bars_held < HISTORY_BARS)
            bars_held++;
        return r;
    endfunction

    function automatic void add_bar(input logic [31:0] h, input logic [31:0] l,
                                    input logic [31:0] v, input logic s);
        bar_t b;
        b.high = h;
        b.low = l;
        b.volume = v;
        b.start = s;
        bars_to_send.push_back(b);
        gen_high = h;
        gen_low = l;
        gen_vol = v;
        bars_added++;
    endfunction

    // Mostly a scaled copy of the previous volume, sometimes zero or wild
    function automatic logic [31:0] pick_volume(input logic [31:0] prev);
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = 64'd0;
            1: v = 64'($urandom);
            2: v = 64'($urandom_range(20));
            default:
            begin
                if (prev == '0)
                    v = 64'($urandom_range(1000, 1));
                else
                    v = (64'(prev) * 64'($urandom_range(450))) / 64'd100;
            end
        endcase
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // One series: an opening bar, then a run of outside, inside, flat and noise bars
    function automatic void add_sequence();
        int          n;
        int          k;
        logic [31:0] h;
        logic [31:0] l;
        logic [63:0] pr;
        logic [63:0] up;
        logic [63:0] dn;
        logic [63:0] room;
        logic [63:0] w;
        logic [63:0] lo_wide;
        if ($urandom_range(1))
        begin
            h = $urandom_range(300, 50);
            l = h - $urandom_range(20);
        end
        else
        begin
            l = $urandom_range(32'hC000_0000, 32'h4000_0000);
            h = l + $urandom_range(1 << 20);
        end
        add_bar(h, l, pick_volume(gen_vol), $urandom_range(7) != 0);
        n = $urandom_range(12, 2);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    // widen on both sides, up to about thirteen times the last range
                    pr = 64'(price_span(gen_high, gen_low));
                    up = 64'd1 + (pr * 64'($urandom_range(600))) / 64'd100
                         + 64'($urandom_range(3));
                    dn = 64'd1 + (pr * 64'($urandom_range(600))) / 64'd100
                         + 64'($urandom_range(3));
                    if (pr == 64'd0 && $urandom_range(1))
                        up = up + 64'($urandom_range(1000));
                    h = (64'(gen_high) + up > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : 32'(64'(gen_high) + up);
                    l = (64'(gen_low) < dn) ? 32'd0 : 32'(64'(gen_low) - dn);
                    add_bar(h, l, pick_volume(gen_vol), 1'b0);
                end
                8, 9, 10, 11, 12, 13, 14:
                begin
                    // place a narrower bar strictly within the last one
                    if (64'(gen_high) > 64'(gen_low) + 64'd1)
                    begin
                        room = 64'(gen_high) - 64'(gen_low) - 64'd2;
                        w = (room * 64'($urandom_range(100))) / 64'd100;
                        lo_wide = 64'(gen_low) + 64'd1
                                  + ((room - w) * 64'($urandom_range(100))) / 64'd100;
                        l = lo_wide[31:0];
                        h = l + w[31:0];
                        if ($urandom_range(9) == 0)
                            {h, l} = {l, h};
                        add_bar(h, l, pick_volume(gen_vol), 1'b0);
                    end
                    else
                    begin
                        add_bar($urandom, $urandom, pick_volume(gen_vol), 1'b0);
                    end
                end
                15, 16:
                begin
                    add_bar(gen_high, gen_low, pick_volume(gen_vol), 1'b0);
                end
                default:
                begin
                    add_bar($urandom, $urandom, pick_volume(gen_vol),
                            $urandom_range(9) == 0);
                end
            endcase
        end
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (bars_to_send.size() != 0 || bar_valid || ranks_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        @(negedge clk);
        target = bars_added + count;
        while (bars_added < target)
            add_sequence();
        wait_drained();
    endtask

    // Write every threshold, holding the enable high across the burst
    task automatic program_thresholds(input thr_set_t how);
        int          i;
        logic [15:0] v;
        for (i = 0; i < NUM_REGS; i++)
        begin
            case (how)
                THR_ZERO:   v = 16'h0000;
                THR_FULL:   v = 16'hFFFF;
                THR_RANDOM: v = $urandom_range(3) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(1000));
                default:    v = default_threshold(REG_IDX_W'(i));
            endcase
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data <= v;
            thr[i] = v;
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Drive bar transactions; predict each one as it is accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bar_valid <= 1'b0;
        end
        else
        begin
            if (bar_valid && bar_ready)
            begin
                ranks_due.push_back(rank_bar(on_wire));
            end
            if (!bar_valid || bar_ready)
            begin
                if (bars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_wire = bars_to_send.pop_front();
                    bar_valid <= 1'b1;
                    bar_high <= on_wire.high;
                    bar_low <= on_wire.low;
                    bar_volume <= on_wire.volume;
                    series_start <= on_wire.start;
                end
                else
                begin
                    bar_valid <= 1'b0;
                end
            end
        end
    end

    // Check rank transactions against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rank_ready <= 1'b0;
        end
        else
        begin
            if (rank_valid && rank_ready)
            begin
                if (ranks_due.size() == 0)
                begin
                    flag_error("rank transaction with no bar outstanding");
                end
                else
                begin
                    next_due = ranks_due.pop_front();
                    if (bar_kind !== next_due.kind)
                        flag_error($sformatf("bar_kind %0d, expected %0d",
                                             bar_kind, next_due.kind));
                    if (rank_half_points !== next_due.half)
                        flag_error($sformatf("rank_half_points %0d, expected %0d",
                                             rank_half_points, next_due.half));
                    if (rank_level !== next_due.level)
                        flag_error($sformatf("rank_level %0d, expected %0d",
                                             rank_level, next_due.level));
                end
            end
            rank_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bar_valid && bar_ready) || (rank_valid && rank_ready) || cfg_write_en)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        int i;
        // Assert reset once every process is waiting, so the falling edge is seen
        rst_n <= 1'b0;
        for (i = 0; i < NUM_REGS; i++)
            thr[i] = default_threshold(REG_IDX_W'(i));
        for (i = 0; i < HISTORY_BARS; i++)
        begin
            prior_high[i] = '0;
            prior_low[i] = '0;
        end

        // First bar after reset, then basic outside, inside and neutral bars
        add_bar(32'd100, 32'd90, 32'd1000, 1'b0);
        add_bar(32'd200, 32'd10, 32'd5000, 1'b0);
        add_bar(32'd150, 32'd50, 32'd100, 1'b0);
        add_bar(32'd149, 32'd51, 32'd100, 1'b0);
        add_bar(32'd149, 32'd60, 32'd100, 1'b0);
        add_bar(32'd300, 32'd0, 32'd0, 1'b0);
        add_bar(32'd400, 32'd0, 32'd500, 1'b0);
        // Zero previous range and volume, then a full engulfing chain
        add_bar(32'd50, 32'd50, 32'd0, 1'b1);
        add_bar(32'd60, 32'd40, 32'd7, 1'b0);
        add_bar(32'd70, 32'd30, 32'd0, 1'b0);
        add_bar(32'd80, 32'd20, 32'd0, 1'b0);
        add_bar(32'd1000, 32'd1, 32'd300, 1'b0);
        // Inside geometry with a zero volume on either side
        add_bar(32'd500, 32'd10, 32'd0, 1'b0);
        add_bar(32'd400, 32'd20, 32'd5, 1'b0);
        // An inside bar, an inverted bar inside it, then outside of the inverted bar
        add_bar(32'd300, 32'd100, 32'd5, 1'b0);
        add_bar(32'd150, 32'd250, 32'd1, 1'b0);
        add_bar(32'd400, 32'd50, 32'd1, 1'b0);
        // Exact threshold boundaries
        add_bar(32'd110, 32'd100, 32'd100, 1'b1);
        add_bar(32'd135, 32'd85, 32'd150, 1'b0);
        // Field extremes
        add_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
        add_bar(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
        add_bar(32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFF, 1'b0);
        add_bar(32'hFFFF_FFFD, 32'd2, 32'd1, 1'b0);
        // Short history after a restart
        add_bar(32'd20, 32'd10, 32'd10, 1'b1);
        add_bar(32'd30, 32'd5, 32'd10, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(0, 0, 380);
        program_thresholds(THR_ZERO);
        run_phase(83, 0, 300);
        program_thresholds(THR_FULL);
        run_phase(0, 83, 300);
        program_thresholds(THR_RANDOM);
        run_phase(9, 9, 300);
        program_thresholds(THR_RANDOM);
        run_phase(0, 0, 300);
        program_thresholds(THR_DEFAULT);
        run_phase(83, 83, 300);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
